// ===== src/lsp_pkg.sv =====
`default_nettype none

package lsp_pkg;

	// defaults for the top level parameters
	localparam int SLOTS_DEF       = 64;
	localparam int TICKET_BITS_DEF = 16;

	// fixed field widths
	localparam int MODE_W        = 2;
	localparam int SLOT_FIELD_W  = 6;
	localparam int TICKET_IN_W   = 16;
	localparam int RND_W         = 31;
	localparam int TOTAL_W       = 22;
	localparam int STEP_W        = $clog2(RND_W);

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// item modes
	localparam logic [MODE_W-1:0] MODE_TICKETS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ELIG    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DRAW    = 2'd2;

	// datapath operations
	localparam logic [2:0] DP_NOP  = 3'd0;
	localparam logic [2:0] DP_CLR  = 3'd1;
	localparam logic [2:0] DP_SUM  = 3'd2;
	localparam logic [2:0] DP_LOAD = 3'd3;
	localparam logic [2:0] DP_MOD  = 3'd4;
	localparam logic [2:0] DP_WALK = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic       vld;
	} lsp_dp_ctl_t;

	typedef struct packed {
		logic hit;
		logic zero;
	} lsp_dp_sts_t;

endpackage

`default_nettype wire

// ===== src/lsp_ram.sv =====
`default_nettype none

module lsp_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/lsp_dp.sv =====
`default_nettype none

module lsp_dp #(
	parameter int TICKET_BITS = 16,
	parameter int SLOT_W      = 6,
	parameter int TW          = TICKET_BITS + SLOT_W
) (
	input  wire logic                     clk,
	input  wire lsp_pkg::lsp_dp_ctl_t     ctl,
	input  wire logic [TICKET_BITS-1:0]   tk,
	input  wire logic                     el,
	input  wire logic [lsp_pkg::RND_W-1:0] rnd,
	output lsp_pkg::lsp_dp_sts_t          sts,
	output logic      [TW-1:0]            total
);

	import lsp_pkg::*;

	logic [TW-1:0]    acc_q;
	logic [TW-1:0]    tot_q;
	logic [TW-1:0]    rem_q;
	logic [RND_W-1:0] rnd_q;

	logic [TW-1:0]    add_sum;
	logic [TW:0]      min_v;
	logic [TW-1:0]    sub_v;
	logic [TW+1:0]    diff;
	logic             borrow;
	logic             take;

	// one adder, shared by sum and walk, and one subtract/compare, shared by modulo and walk
	assign add_sum = acc_q + TW'(tk);
	assign take    = ctl.vld && el;

	always_comb begin
		if (ctl.op == DP_MOD) begin
			min_v = {rem_q, rnd_q[RND_W-1]};
			sub_v = tot_q;
		end else begin
			min_v = {1'b0, rem_q};
			sub_v = add_sum;
		end
	end

	assign diff   = {1'b0, min_v} - {2'b00, sub_v};
	assign borrow = diff[TW+1];

	// walk: draw < running sum means this slot wins
	assign sts.hit  = (ctl.op == DP_WALK) && take && borrow;
	assign sts.zero = (acc_q == '0);
	assign total    = tot_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			DP_CLR: begin
				acc_q <= '0;
				rnd_q <= rnd;
			end
			DP_SUM: begin
				if (take) begin
					acc_q <= add_sum;
				end
			end
			DP_LOAD: begin
				tot_q <= acc_q;
				acc_q <= '0;
				rem_q <= '0;
			end
			DP_MOD: begin
				// restoring step, one quotient bit per cycle
				rem_q <= borrow ? min_v[TW-1:0] : diff[TW-1:0];
				rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
			end
			DP_WALK: begin
				if (take) begin
					acc_q <= add_sum;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/lottery_slot_picker_core.sv =====
`default_nettype none

// channel   signals                 payload
// input     in_valid / in_stall     mode, slot, ticket_count, eligible, random_word
// output    out_valid / out_stall   winner_slot, winner_valid, total_tickets
//
// ticket and eligible writes go from accept through the done state to the result register.
// a draw is a sum pass over the ticket memory, 31 steps of the shared subtract
// unit for the modulo, then a walk pass that stops at the winner; the single
// memory read port sets the passes.
// after reset a clearing pass over every slot zeroes both memories, in_stall high.
// a finished result waits in the output register while the next item is accepted.

module lottery_slot_picker_core #(
	parameter int SLOTS       = lsp_pkg::SLOTS_DEF,
	parameter int TICKET_BITS = lsp_pkg::TICKET_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [lsp_pkg::MODE_W-1:0]       mode,
	input  wire logic [lsp_pkg::SLOT_FIELD_W-1:0] slot,
	input  wire logic [lsp_pkg::TICKET_IN_W-1:0]  ticket_count,
	input  wire logic                             eligible,
	input  wire logic [lsp_pkg::RND_W-1:0]        random_word,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [lsp_pkg::SLOT_FIELD_W-1:0] winner_slot,
	output logic                                  winner_valid,
	output logic      [lsp_pkg::TOTAL_W-1:0]      total_tickets
);

	import lsp_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int TW     = TICKET_BITS + SLOT_W;
	localparam int CW     = (TW > TOTAL_W) ? TW : TOTAL_W;
	localparam int CMP_W  = (SLOT_FIELD_W > CNT_W) ? SLOT_FIELD_W : CNT_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SUM   = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [STEP_W-1:0]       step_q;
	logic                    rd_vld_s1;
	logic [SLOT_W-1:0]       rd_idx_s1;
	logic [SLOT_FIELD_W-1:0] cur_slot_q;
	logic                    cur_valid_q;
	logic [TOTAL_W-1:0]      last_total_q;
	logic                    rep_q;
	logic                    out_valid_q;
	logic [SLOT_FIELD_W-1:0] out_slot_q;
	logic                    out_flag_q;
	logic [TOTAL_W-1:0]      out_total_q;

	logic                    accept;
	logic                    in_range;
	logic [SLOT_W-1:0]       slot_idx;
	logic                    reading;
	logic                    issue;
	logic                    pass_done;
	logic                    out_free;
	logic                    clearing;

	logic                    tk_we;
	logic                    el_we;
	logic [SLOT_W-1:0]       waddr;
	logic [TICKET_BITS-1:0]  tk_wdata;
	logic                    el_wdata;
	logic [TICKET_BITS-1:0]  tk_rdata;
	logic                    el_rdata;

	lsp_dp_ctl_t             dp_ctl;
	lsp_dp_sts_t             dp_sts;
	logic [TW-1:0]           dp_total;
	logic [CW-1:0]           tot_ext;
	logic [TOTAL_W-1:0]      tot_sat;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = (CMP_W'(slot) < CMP_W'(SLOTS));
	assign slot_idx = SLOT_W'(slot);

	assign reading   = (state_q == S_SUM) || (state_q == S_WALK);
	assign issue     = reading && (cnt_q != CNT_W'(SLOTS));
	assign pass_done = reading && !issue && !rd_vld_s1;
	assign out_free  = !out_valid_q || !out_stall;
	assign clearing  = (state_q == S_CLEAR);

	assign tk_we    = clearing || (accept && (mode == MODE_TICKETS) && in_range);
	assign el_we    = clearing || (accept && (mode == MODE_ELIG) && in_range);
	assign waddr    = clearing ? cnt_q[SLOT_W-1:0] : slot_idx;
	assign tk_wdata = clearing ? '0 : TICKET_BITS'(ticket_count);
	assign el_wdata = clearing ? 1'b0 : eligible;

	lsp_ram #(
		.DEPTH (SLOTS),
		.WIDTH (TICKET_BITS),
		.AW    (SLOT_W)
	) u_tk_ram (
		.clk   (clk),
		.we    (tk_we),
		.waddr (waddr),
		.wdata (tk_wdata),
		.raddr (cnt_q[SLOT_W-1:0]),
		.rdata (tk_rdata)
	);

	lsp_ram #(
		.DEPTH (SLOTS),
		.WIDTH (1),
		.AW    (SLOT_W)
	) u_el_ram (
		.clk   (clk),
		.we    (el_we),
		.waddr (waddr),
		.wdata (el_wdata),
		.raddr (cnt_q[SLOT_W-1:0]),
		.rdata (el_rdata)
	);

	always_comb begin
		dp_ctl.vld = rd_vld_s1;
		case (state_q)
			S_IDLE:  dp_ctl.op = (accept && (mode == MODE_DRAW)) ? DP_CLR : DP_NOP;
			S_SUM: begin
				if (pass_done) begin
					dp_ctl.op = dp_sts.zero ? DP_NOP : DP_LOAD;
				end else begin
					dp_ctl.op = DP_SUM;
				end
			end
			S_MOD:   dp_ctl.op = DP_MOD;
			S_WALK:  dp_ctl.op = DP_WALK;
			default: dp_ctl.op = DP_NOP;
		endcase
	end

	lsp_dp #(
		.TICKET_BITS (TICKET_BITS),
		.SLOT_W      (SLOT_W),
		.TW          (TW)
	) u_dp (
		.clk   (clk),
		.ctl   (dp_ctl),
		.tk    (tk_rdata),
		.el    (el_rdata),
		.rnd   (random_word),
		.sts   (dp_sts),
		.total (dp_total)
	);

	// reported total saturates at the field width
	assign tot_ext = CW'(dp_total);
	assign tot_sat = (tot_ext > CW'(TOTAL_MAX)) ? TOTAL_MAX : tot_ext[TOTAL_W-1:0];

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[SLOT_W-1:0];
		if (state_q == S_DONE && out_free) begin
			out_slot_q  <= cur_slot_q;
			out_flag_q  <= rep_q;
			out_total_q <= last_total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			step_q       <= '0;
			rd_vld_s1    <= 1'b0;
			cur_slot_q   <= '0;
			cur_valid_q  <= 1'b0;
			last_total_q <= '0;
			rep_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					if (cnt_q == CNT_W'(SLOTS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_DRAW) begin
							cnt_q   <= '0;
							state_q <= S_SUM;
						end else begin
							rep_q   <= cur_valid_q;
							state_q <= S_DONE;
						end
					end
				end
				S_SUM: begin
					if (pass_done) begin
						cnt_q <= '0;
						if (dp_sts.zero) begin
							// empty draw keeps the current slot
							last_total_q <= '0;
							rep_q        <= 1'b0;
							state_q      <= S_DONE;
						end else begin
							step_q  <= '0;
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					last_total_q <= tot_sat;
					if (step_q == STEP_W'(RND_W - 1)) begin
						state_q <= S_WALK;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_WALK: begin
					if (dp_sts.hit) begin
						cur_slot_q  <= SLOT_FIELD_W'(rd_idx_s1);
						cur_valid_q <= 1'b1;
						rep_q       <= 1'b1;
						state_q     <= S_DONE;
					end else if (pass_done) begin
						rep_q   <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign winner_slot   = out_slot_q;
	assign winner_valid  = out_flag_q;
	assign total_tickets = out_total_q;

endmodule

`default_nettype wire

// ===== verif/tb_lottery_slot_picker_core.sv =====
`default_nettype none

module tb_lottery_slot_picker_core;
	import lsp_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int NUM_SLOTS = SLOTS_DEF;
	localparam int RAND_ITEMS = 1095;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 2500;

	typedef struct {
		logic [MODE_W-1:0]       mode;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [TICKET_IN_W-1:0]  tickets;
		logic                    elig;
		logic [RND_W-1:0]        rnd;
		int                      gap;
		bit                      drain;
	} item_t;

	typedef struct {
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    valid;
		logic [TOTAL_W-1:0]      total;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_W-1:0] mode = '0;
	logic [SLOT_FIELD_W-1:0] slot = '0;
	logic [TICKET_IN_W-1:0] ticket_count = '0;
	logic eligible = 1'b0;
	logic [RND_W-1:0] random_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SLOT_FIELD_W-1:0] winner_slot;
	logic winner_valid;
	logic [TOTAL_W-1:0] total_tickets;

	// scheduler state as the testbench sees it
	logic [TICKET_IN_W-1:0] tix [NUM_SLOTS];
	logic runnable [NUM_SLOTS];
	logic [SLOT_FIELD_W-1:0] cur_slot = '0;
	logic cur_valid = 1'b0;
	logic [TOTAL_W-1:0] last_sum = '0;

	item_t item_q[$];
	outcome_t outcome_q[$];
	item_t cur_item;
	int sent_n = 0;
	int got_n = 0;
	int bad_n = 0;
	int tx_wait = 0;
	int stall_left = 0;
	int hold_left = 0;
	logic hold_off = 1'b0;
	bit hold_done = 1'b0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit drain_next = 1'b0;

	lottery_slot_picker_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.slot(slot),
		.ticket_count(ticket_count),
		.eligible(eligible),
		.random_word(random_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.winner_slot(winner_slot),
		.winner_valid(winner_valid),
		.total_tickets(total_tickets)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic outcome_t pick_outcome(item_t it);
		outcome_t o;
		logic [63:0] sum;
		logic [63:0] pick;
		logic [63:0] run;
		bit found;
		logic rep_valid;
		sum = '0;
		run = '0;
		found = 1'b0;
		case (it.mode)
			MODE_TICKETS: tix[it.slot] = it.tickets;
			MODE_ELIG: runnable[it.slot] = it.elig;
			default: ;
		endcase
		rep_valid = cur_valid;
		if (it.mode == MODE_DRAW) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				if (runnable[i])
					sum += 64'(tix[i]);
			last_sum = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
			rep_valid = 1'b0;
			if (sum != 0) begin
				pick = 64'(it.rnd) % sum;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!found && runnable[i]) begin
						run += 64'(tix[i]);
						if (run > pick) begin
							found = 1'b1;
							cur_slot = i[SLOT_FIELD_W-1:0];
							cur_valid = 1'b1;
							rep_valid = 1'b1;
						end
					end
				end
			end
		end
		o.slot = cur_slot;
		o.valid = rep_valid;
		o.total = last_sum;
		return o;
	endfunction

	task automatic add_item(input logic [MODE_W-1:0] m, input logic [SLOT_FIELD_W-1:0] s,
			input logic [TICKET_IN_W-1:0] t, input logic e, input logic [RND_W-1:0] r);
		item_t it;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		it.mode = m;
		it.slot = s;
		it.tickets = t;
		it.elig = e;
		it.rnd = r;
		it.gap = tx_calm ? 0 : $urandom_range(0, 19);
		it.drain = drain_next;
		drain_next = 1'b0;
		item_q.push_back(it);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait <= 0;
			sent_n <= 0;
		end else begin
			item_t nxt;
			if (in_valid && !in_stall) begin
				outcome_q.push_back(pick_outcome(cur_item));
				sent_n <= sent_n + 1;
			end
			if (!in_valid || !in_stall) begin
				if (item_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (item_q[0].drain && (in_valid || sent_n != got_n)) begin
					// wait until every outstanding result is back
					in_valid <= 1'b0;
				end else if (tx_wait < item_q[0].gap) begin
					in_valid <= 1'b0;
					tx_wait <= tx_wait + 1;
				end else begin
					nxt = item_q.pop_front();
					cur_item <= nxt;
					mode <= nxt.mode;
					slot <= nxt.slot;
					ticket_count <= nxt.tickets;
					eligible <= nxt.elig;
					random_word <= nxt.rnd;
					in_valid <= 1'b1;
					tx_wait <= 0;
				end
			end
		end
	end

	// one long receiver hold-off while the sender keeps offering items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && got_n >= HOLD_AFTER) begin
			hold_off <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			hold_off <= (hold_left != 1);
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			got_n <= 0;
		end else begin
			int left_v;
			outcome_t exp_o;
			left_v = stall_left;
			if (out_valid && !out_stall) begin
				if (got_n == sent_n) begin
					$error("result with no item outstanding: slot %0d valid %0d total %0d",
						winner_slot, winner_valid, total_tickets);
					bad_n++;
				end else begin
					exp_o = outcome_q.pop_front();
					got_n <= got_n + 1;
					if (winner_slot !== exp_o.slot) begin
						$error("winner_slot expected %0d got %0d", exp_o.slot, winner_slot);
						bad_n++;
					end
					if (winner_valid !== exp_o.valid) begin
						$error("winner_valid expected %0d got %0d", exp_o.valid, winner_valid);
						bad_n++;
					end
					if (total_tickets !== exp_o.total) begin
						$error("total_tickets expected %0d got %0d", exp_o.total, total_tickets);
						bad_n++;
					end
				end
				if ($urandom_range(0, 29) == 0)
					rx_calm = !rx_calm;
				left_v = rx_calm ? 0 : $urandom_range(0, 19);
			end else if (left_v != 0) begin
				left_v--;
			end
			stall_left <= left_v;
			out_stall <= hold_off || (left_v != 0);
		end
	end

	initial begin
		logic [TICKET_IN_W-1:0] t;
		logic [RND_W-1:0] r;
		int sel;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			tix[i] = '0;
			runnable[i] = 1'b0;
		end

		// directed: empty table, spare mode, field extremes, zero-ticket runnable slot
		add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'd0);
		add_item(MODE_SPARE, 6'd63, 16'hffff, 1'b1, 31'h7fffffff);
		add_item(MODE_TICKETS, 6'd0, 16'hffff, 1'b0, 31'd0);
		add_item(MODE_TICKETS, 6'd63, 16'd1, 1'b1, 31'h7fffffff);
		add_item(MODE_DRAW, 6'd63, 16'hffff, 1'b1, 31'h7fffffff);
		add_item(MODE_ELIG, 6'd0, 16'd0, 1'b1, 31'd0);
		add_item(MODE_ELIG, 6'd63, 16'd0, 1'b1, 31'd0);
		add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'd0);
		add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'd65535);
		add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'h7fffffff);
		add_item(MODE_TICKETS, 6'd0, 16'd0, 1'b1, 31'd0);
		add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'h1234567);
		add_item(MODE_ELIG, 6'd63, 16'd0, 1'b0, 31'd0);
		add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'h7fffffff);
		add_item(MODE_SPARE, 6'd0, 16'd0, 1'b0, 31'd0);
		add_item(MODE_TICKETS, 6'd42, 16'h5555, 1'b0, 31'h2aaaaaaa);
		add_item(MODE_TICKETS, 6'd21, 16'haaaa, 1'b1, 31'h55555555);
		add_item(MODE_ELIG, 6'd42, 16'h5555, 1'b1, 31'd0);
		add_item(MODE_ELIG, 6'd21, 16'haaaa, 1'b1, 31'd0);
		add_item(MODE_DRAW, 6'd21, 16'd0, 1'b0, 31'h2aaaaaaa);
		add_item(MODE_DRAW, 6'd42, 16'd0, 1'b1, 31'h55555555);
		add_item(MODE_ELIG, 6'd0, 16'd0, 1'b0, 31'd0);
		add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'd1);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 250 == 0)
				drain_next = 1'b1;
			if (n == 500) begin
				// every slot full and runnable: largest possible total
				for (int i = 0; i < NUM_SLOTS; i++)
					add_item(MODE_TICKETS, i[SLOT_FIELD_W-1:0], 16'hffff, 1'b0, 31'd0);
				for (int i = 0; i < NUM_SLOTS; i++)
					add_item(MODE_ELIG, i[SLOT_FIELD_W-1:0], 16'd0, 1'b1, 31'd0);
				add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'd0);
				add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'h7fffffff);
				add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'd4194239);
				add_item(MODE_DRAW, 6'd0, 16'd0, 1'b0, 31'(32'($urandom) & 32'h7fffffff));
			end
			sel = $urandom_range(0, 99);
			case ($urandom_range(0, 7))
				0: t = '0;
				1: t = '1;
				2, 3: t = TICKET_IN_W'($urandom_range(1, 15));
				default: t = TICKET_IN_W'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 15))
				0: r = '0;
				1: r = '1;
				default: r = 31'(32'($urandom) & 32'h7fffffff);
			endcase
			if (sel < 34)
				add_item(MODE_TICKETS, SLOT_FIELD_W'($urandom_range(0, 63)), t,
					1'($urandom_range(0, 1)), r);
			else if (sel < 62)
				add_item(MODE_ELIG, SLOT_FIELD_W'($urandom_range(0, 63)), t,
					$urandom_range(0, 9) < 7, r);
			else if (sel < 96)
				add_item(MODE_DRAW, SLOT_FIELD_W'($urandom_range(0, 63)), t,
					1'($urandom_range(0, 1)), r);
			else
				add_item(MODE_SPARE, SLOT_FIELD_W'($urandom_range(0, 63)), t,
					1'($urandom_range(0, 1)), r);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (item_q.size() != 0 || in_valid || sent_n != got_n)
			@(negedge clk);
		repeat (300) @(negedge clk);
		if (bad_n == 0 && outcome_q.size() == 0)
			$display("tb_lottery_slot_picker_core: done, clean");
		else
			$display("tb_lottery_slot_picker_core: done, errors");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_lottery_slot_picker_core: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
